// File: hdl/camera_ray_direction_defines.svh
// Assertion helpers for the camera ray direction RTL
`ifndef CAMERA_RAY_DIRECTION_DEFINES_SVH
`define CAMERA_RAY_DIRECTION_DEFINES_SVH

// Same-cycle implication, quiet during reset
`define CRD_ASSERT_NOW(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, quiet during reset
`define CRD_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: hdl/crd_pkg.sv
package crd_pkg;

  // Normalized magnitude, sum of squares, root and quotient widths
  localparam int MAG_N  = 30;
  localparam int S_W    = 62;
  localparam int ROOT_W = 31;
  localparam int Q_W    = 17;
  localparam int REM_W  = 48;
  localparam int COMP_W = 21;
  localparam int DIR_W  = 18;
  localparam int VEC_W  = 63;
  localparam logic [Q_W-1:0] Q_ONE = Q_W'(65536);

  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_PIXEL_PITCH  = 3'd2,
    REG_RIGHT_AXIS   = 3'd3,
    REG_UP_AXIS      = 3'd4,
    REG_LOOK_AT      = 3'd5,
    REG_EYE          = 3'd6
  } reg_index_t;

  // Data that rides along the root and divide stages
  typedef struct packed {
    logic                        zero;
    logic [2:0]                  neg;
    logic [2:0][MAG_N-1:0]       mag;
  } side_t;

  // Pull one signed Q6.14 component out of a packed vector
  function automatic logic signed [COMP_W-1:0] vec_comp(input logic [VEC_W-1:0] v,
                                                         input int idx);
    logic [VEC_W-1:0] s;
    s = v >> (COMP_W * idx);
    return s[COMP_W-1:0];
  endfunction

endpackage

// File: hdl/camera_ray_direction.sv
// Pinhole camera primary ray direction.
// Slave stream: one item per pixel, tdata = {jitter_y, jitter_x, pixel_row,
// pixel_col} from the high bit down. Master stream: one item per input item,
// tdata = {dir_z, dir_y, dir_x} signed Q1.16, tuser = zero_length.
// Configuration: write cfg_data to register cfg_index while cfg_we is high;
// registers are image width, height, pixel pitch, right axis, up axis,
// look-at point and eye point. Write only when the block is empty.
// From input accept to output valid an item passes 10 offset, axis
// multiply, sum, normalize and square stages, 31 square root stages
// (one root bit per stage), 17 divide stages (one quotient bit per
// stage) and the output register.
// Throughput is one item per clock unless the receiver stalls; every stage is registered.
// Reset clears all stage valid bits and restores the default camera.
// When the receiver stalls with a result held, the whole pipeline freezes
// and s_axis_tready drops; no item is lost or repeated.
`include "camera_ray_direction_defines.svh"
module camera_ray_direction
  import crd_pkg::*;
#(
  parameter int PIXEL_INDEX_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [VEC_W-1:0]      cfg_data,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // pixel_col, pixel_row, jitter_x, jitter_y
  input  logic [((2*PIXEL_INDEX_BITS+32+7)/8)*8-1:0] s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // dir_x, dir_y, dir_z
  output logic [55:0]           m_axis_tdata,
  // zero_length
  output logic                  m_axis_tuser
);

  localparam int P     = PIXEL_INDEX_BITS;
  localparam int HV_W  = ((P + 16 > 28) ? P + 16 : 28) + 2;
  localparam int HP_W  = HV_W + 25;
  localparam int HS_W  = HV_W + 5;
  localparam int PR_W  = HS_W + COMP_W;
  localparam int D_W   = HS_W + 23;
  localparam int LEN_W = $clog2(D_W + 1);

  // Configuration registers
  logic [12:0]      image_width;
  logic [12:0]      image_height;
  logic [23:0]      pixel_pitch;
  logic [VEC_W-1:0] right_axis;
  logic [VEC_W-1:0] up_axis;
  logic [VEC_W-1:0] look_at;
  logic [VEC_W-1:0] eye;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 13'd640;
      image_height <= 13'd480;
      pixel_pitch  <= 24'd65536;
      right_axis   <= VEC_W'(16384);
      up_axis      <= VEC_W'(16384) << COMP_W;
      look_at      <= '0;
      eye          <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[12:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[12:0];
        REG_PIXEL_PITCH:  pixel_pitch  <= cfg_data[23:0];
        REG_RIGHT_AXIS:   right_axis   <= cfg_data;
        REG_UP_AXIS:      up_axis      <= cfg_data;
        REG_LOOK_AT:      look_at      <= cfg_data;
        REG_EYE:          eye          <= cfg_data;
        default: ;
      endcase
    end
  end

  // Global advance: move when the output register is free or being taken
  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic [P-1:0] pixel_col;
  logic [P-1:0] pixel_row;
  logic [15:0]  jitter_x;
  logic [15:0]  jitter_y;
  assign pixel_col = s_axis_tdata[P-1:0];
  assign pixel_row = s_axis_tdata[2*P-1:P];
  assign jitter_x  = s_axis_tdata[2*P+15:2*P];
  assign jitter_y  = s_axis_tdata[2*P+31:2*P+16];

  function automatic logic [LEN_W-1:0] bit_len(input logic [D_W-1:0] x);
    logic [LEN_W-1:0] n;
    n = '0;
    for (int i = 0; i < D_W; i++) begin
      if (x[i]) n = LEN_W'(i + 1);
    end
    return n;
  endfunction

  // Stage valid bits
  logic vld1, vld2, vld3, vld4, vld5, vld6, vld7, vld8, vld9, vld10;

  always_ff @(posedge clk) begin
    if (rst) begin
      {vld1, vld2, vld3, vld4, vld5, vld6, vld7, vld8, vld9, vld10} <= '0;
    end else if (en) begin
      vld1  <= s_axis_tvalid;
      vld2  <= vld1;
      vld3  <= vld2;
      vld4  <= vld3;
      vld5  <= vld4;
      vld6  <= vld5;
      vld7  <= vld6;
      vld8  <= vld7;
      vld9  <= vld8;
      vld10 <= vld9;
    end
  end

  // Stage payloads
  logic signed [HV_W-1:0]          h1, v1;
  logic signed [HP_W-1:0]          hp2, vp2;
  logic signed [2:0][PR_W-1:0]     pr3, pu3;
  logic signed [2:0][COMP_W:0]     doff3;
  logic signed [2:0][D_W-1:0]      d4;
  logic [2:0][D_W-1:0]             mag5, mag6, mag7;
  logic [2:0]                      neg5, neg6, neg7;
  logic [D_W-1:0]                  m6;
  logic [LEN_W-1:0]                len7;
  logic                            zero7;
  side_t                           side8, side9, side10;
  logic [2:0][2*MAG_N-1:0]         sq9;
  logic [S_W-1:0]                  sum10;

  logic signed [HP_W-1:0] hp_rnd, vp_rnd;
  logic signed [HS_W-1:0] hs, vs;
  assign hp_rnd = hp2 + HP_W'(524288);
  assign vp_rnd = vp2 + HP_W'(524288);
  assign hs     = HS_W'(hp_rnd >>> 20);
  assign vs     = HS_W'(vp_rnd >>> 20);

  logic [D_W-1:0] m5;
  always_comb begin
    m5 = mag5[0];
    if (mag5[1] > m5) m5 = mag5[1];
    if (mag5[2] > m5) m5 = mag5[2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Offsets from image center in Q.16
      h1 <= (HV_W'(pixel_col) << 16) - (HV_W'(image_width) << 15) + HV_W'(jitter_x);
      v1 <= (HV_W'(image_height) << 15) - (HV_W'(pixel_row) << 16) + HV_W'(jitter_y);
      // Scale by pitch
      hp2 <= h1 * $signed({1'b0, pixel_pitch});
      vp2 <= v1 * $signed({1'b0, pixel_pitch});
      // Round to Q.20 and project onto the camera axes
      for (int i = 0; i < 3; i++) begin
        pr3[i]   <= hs * vec_comp(right_axis, i);
        pu3[i]   <= vs * vec_comp(up_axis, i);
        doff3[i] <= (COMP_W+1)'(vec_comp(look_at, i)) - (COMP_W+1)'(vec_comp(eye, i));
      end
      // Sum into the direction vector, Q.34; lanes are sign-extended
      for (int i = 0; i < 3; i++) begin
        d4[i] <= D_W'($signed(pr3[i])) + D_W'($signed(pu3[i]))
               + (D_W'($signed(doff3[i])) << 20);
      end
      // Sign and magnitude
      for (int i = 0; i < 3; i++) begin
        neg5[i] <= $signed(d4[i]) < 0;
        mag5[i] <= ($signed(d4[i]) < 0) ? D_W'(-d4[i]) : D_W'(d4[i]);
      end
      // Largest magnitude
      m6   <= m5;
      mag6 <= mag5;
      neg6 <= neg5;
      // Its bit length
      len7  <= bit_len(m6);
      zero7 <= m6 == '0;
      mag7  <= mag6;
      neg7  <= neg6;
      // Normalize so the largest lies in [2^29, 2^30)
      side8.zero <= zero7;
      side8.neg  <= neg7;
      for (int i = 0; i < 3; i++) begin
        if (len7 > LEN_W'(MAG_N)) begin
          side8.mag[i] <= MAG_N'(mag7[i] >> (len7 - LEN_W'(MAG_N)));
        end else begin
          side8.mag[i] <= MAG_N'(mag7[i] << (LEN_W'(MAG_N) - len7));
        end
      end
      // Squares
      for (int i = 0; i < 3; i++) begin
        sq9[i] <= side8.mag[i] * side8.mag[i];
      end
      side9 <= side8;
      // Sum of squares
      sum10  <= S_W'(sq9[0]) + S_W'(sq9[1]) + S_W'(sq9[2]);
      side10 <= side9;
    end
  end

  logic              rt_valid;
  logic [ROOT_W-1:0] rt_root;
  side_t             rt_side;

  crd_sqrt_pipe u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vld10),
    .in_sum    (sum10),
    .in_side   (side10),
    .out_valid (rt_valid),
    .out_root  (rt_root),
    .out_side  (rt_side)
  );

  logic                dv_valid;
  logic [2:0][Q_W-1:0] dv_quot;
  side_t               dv_side;

  crd_div_pipe u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (rt_valid),
    .in_root   (rt_root),
    .in_side   (rt_side),
    .out_valid (dv_valid),
    .out_quot  (dv_quot),
    .out_side  (dv_side)
  );

  // Clamp, apply sign, zero out a null vector
  logic [2:0][DIR_W-1:0] dir;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [Q_W-1:0] q;
      q = (dv_quot[i] > Q_ONE) ? Q_ONE : dv_quot[i];
      if (dv_side.zero) begin
        dir[i] = '0;
      end else if (dv_side.neg[i]) begin
        dir[i] = DIR_W'(-$signed({1'b0, q}));
      end else begin
        dir[i] = DIR_W'(q);
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= {2'b00, dir[2], dir[1], dir[0]};
      m_axis_tuser <= dv_side.zero;
    end
  end

  `CRD_ASSERT_NEXT(a_accept_enters, s_axis_tvalid && s_axis_tready, vld1, "accepted item did not enter stage one")
  `CRD_ASSERT_NOW(a_empty_ready, !m_axis_tvalid, s_axis_tready, "input stalled with empty output")
  `CRD_ASSERT_NOW(a_zero_dir, m_axis_tvalid && m_axis_tuser, m_axis_tdata[53:0] == 54'd0, "null vector with nonzero direction")
  `CRD_ASSERT_NOW(a_dir_range, m_axis_tvalid, ($signed(m_axis_tdata[17:0]) <= 18'sd65536) && ($signed(m_axis_tdata[17:0]) >= -18'sd65536), "dir_x out of range")

endmodule

// File: hdl/crd_sqrt_pipe.sv
module crd_sqrt_pipe
  import crd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [S_W-1:0]    in_sum,
  input  side_t             in_side,
  output logic              out_valid,
  output logic [ROOT_W-1:0] out_root,
  output side_t             out_side
);

  logic              vld  [0:ROOT_W];
  logic [S_W-1:0]    rem  [0:ROOT_W];
  logic [ROOT_W-1:0] root [0:ROOT_W];
  side_t             side [0:ROOT_W];

  assign vld[0]  = in_valid;
  assign rem[0]  = in_sum;
  assign root[0] = '0;
  assign side[0] = in_side;

  // One root bit per stage, most significant first
  for (genvar g = 0; g < ROOT_W; g++) begin : g_step
    localparam int K = ROOT_W - 1 - g;
    logic [S_W-1:0] trial;
    logic           take;

    assign trial = ((S_W'(root[g])) << (K + 1)) + (S_W'(1) << (2 * K));
    assign take  = rem[g] >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (en) begin
        vld[g+1] <= vld[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[g+1]  <= take ? rem[g] - trial : rem[g];
        root[g+1] <= take ? root[g] | (ROOT_W'(1) << K) : root[g];
        side[g+1] <= side[g];
      end
    end
  end

  assign out_valid = vld[ROOT_W];
  assign out_root  = root[ROOT_W];
  assign out_side  = side[ROOT_W];

endmodule

// File: hdl/crd_div_pipe.sv
module crd_div_pipe
  import crd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [ROOT_W-1:0]     in_root,
  input  side_t                 in_side,
  output logic                  out_valid,
  output logic [2:0][Q_W-1:0]   out_quot,
  output side_t                 out_side
);

  logic                  vld  [0:Q_W];
  logic [2:0][REM_W-1:0] rem  [0:Q_W];
  logic [2:0][Q_W-1:0]   quot [0:Q_W];
  logic [ROOT_W-1:0]     root [0:Q_W];
  side_t                 side [0:Q_W];

  // Dividend is magnitude scaled by 2^16 plus half the root for rounding
  for (genvar l = 0; l < 3; l++) begin : g_init
    assign rem[0][l] = (REM_W'(in_side.mag[l]) << 16) + REM_W'(in_root >> 1);
  end
  assign vld[0]  = in_valid;
  assign quot[0] = '0;
  assign root[0] = in_root;
  assign side[0] = in_side;

  // One quotient bit per stage, three lanes share the divisor
  for (genvar g = 0; g < Q_W; g++) begin : g_step
    localparam int K = Q_W - 1 - g;
    logic [REM_W-1:0] dsh;
    logic [2:0]       take;

    assign dsh = REM_W'(root[g]) << K;
    for (genvar l = 0; l < 3; l++) begin : g_lane
      assign take[l] = rem[g][l] >= dsh;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else if (en) begin
        vld[g+1] <= vld[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 3; l++) begin
          rem[g+1][l]  <= take[l] ? rem[g][l] - dsh : rem[g][l];
          quot[g+1][l] <= take[l] ? quot[g][l] | (Q_W'(1) << K) : quot[g][l];
        end
        root[g+1] <= root[g];
        side[g+1] <= side[g];
      end
    end
  end

  assign out_valid = vld[Q_W];
  assign out_quot  = quot[Q_W];
  assign out_side  = side[Q_W];

endmodule

// File: tb/camera_ray_direction_checker.sv
module camera_ray_direction_checker
  import crd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [VEC_W-1:0]  cfg_data,
  input  logic              s_valid,
  input  logic              s_ready,
  input  logic [55:0]       s_data,
  input  logic              m_valid,
  input  logic              m_ready,
  input  logic [55:0]       m_data,
  input  logic              m_user,
  output int                fail_count,
  output int                pending,
  output int                rays_seen,
  output int                zero_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [DIR_W-1:0] dx;
    logic [DIR_W-1:0] dy;
    logic [DIR_W-1:0] dz;
    logic             zl;
  } ray_t;

  logic [12:0]      cam_w, cam_h;
  logic [23:0]      cam_pitch;
  logic [VEC_W-1:0] cam_right, cam_up, cam_look, cam_eye;
  ray_t             ray_queue[$];

  function automatic longint comp_of(input logic [VEC_W-1:0] v, input int idx);
    logic [VEC_W-1:0] s;
    logic signed [COMP_W-1:0] c;
    s = v >> (COMP_W * idx);
    c = s[COMP_W-1:0];
    return longint'(c);
  endfunction

  // Square root by bit pairs
  function automatic longint unsigned root_of(input longint unsigned s);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s = s - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic ray_t trace_ray(input logic [55:0] d);
    longint col, row, jx, jy, h, v, hs, vs, dd;
    longint unsigned mag[3], m, s, r, q;
    logic neg[3];
    int len;
    ray_t o;
    col = longint'(d[11:0]);
    row = longint'(d[23:12]);
    jx = longint'(d[39:24]);
    jy = longint'(d[55:40]);
    h = col * 65536 - longint'(cam_w) * 32768 + jx;
    v = longint'(cam_h) * 32768 - row * 65536 + jy;
    hs = (h * longint'(cam_pitch) + 524288) >>> 20;
    vs = (v * longint'(cam_pitch) + 524288) >>> 20;
    m = 0;
    for (int i = 0; i < 3; i++) begin
      dd = hs * comp_of(cam_right, i) + vs * comp_of(cam_up, i)
         + (comp_of(cam_look, i) - comp_of(cam_eye, i)) * 1048576;
      neg[i] = dd < 0;
      mag[i] = neg[i] ? longint'(-dd) : longint'(dd);
      if (mag[i] > m) m = mag[i];
    end
    o = '0;
    if (m == 0) begin
      o.zl = 1'b1;
      return o;
    end
    len = 0;
    while (m != 0) begin
      len++;
      m = m >> 1;
    end
    s = 0;
    for (int i = 0; i < 3; i++) begin
      if (len > 30) mag[i] = mag[i] >> (len - 30);
      else mag[i] = mag[i] << (30 - len);
      s += mag[i] * mag[i];
    end
    r = root_of(s);
    for (int i = 0; i < 3; i++) begin
      q = (mag[i] * 65536 + (r >> 1)) / r;
      if (q > 65536) q = 65536;
      if (neg[i]) q = -q;
      if (i == 0) o.dx = q[DIR_W-1:0];
      else if (i == 1) o.dy = q[DIR_W-1:0];
      else o.dz = q[DIR_W-1:0];
    end
    return o;
  endfunction

  // Track registers, predict on input accept, compare on output accept
  always @(posedge clk) begin
    ray_t got, want;
    if (rst) begin
      cam_w <= 13'd640;
      cam_h <= 13'd480;
      cam_pitch <= 24'd65536;
      cam_right <= 63'd16384;
      cam_up <= 63'd16384 << 21;
      cam_look <= '0;
      cam_eye <= '0;
      fail_count <= 0;
      pending <= 0;
      rays_seen <= 0;
      zero_seen <= 0;
      ray_queue.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  cam_w <= cfg_data[12:0];
          REG_IMAGE_HEIGHT: cam_h <= cfg_data[12:0];
          REG_PIXEL_PITCH:  cam_pitch <= cfg_data[23:0];
          REG_RIGHT_AXIS:   cam_right <= cfg_data;
          REG_UP_AXIS:      cam_up <= cfg_data;
          REG_LOOK_AT:      cam_look <= cfg_data;
          REG_EYE:          cam_eye <= cfg_data;
          default: ;
        endcase
      end
      if (s_valid && s_ready) ray_queue.push_back(trace_ray(s_data));
      if (m_valid && m_ready) begin
        got.dx = m_data[17:0];
        got.dy = m_data[35:18];
        got.dz = m_data[53:36];
        got.zl = m_user;
        rays_seen <= rays_seen + 1;
        if (m_user) zero_seen <= zero_seen + 1;
        if (ray_queue.size() == 0) begin
          if (fail_count < 10) $display("unexpected ray out: %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = ray_queue.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("ray mismatch: exp x=%h y=%h z=%h zl=%b got x=%h y=%h z=%h zl=%b",
                       want.dx, want.dy, want.dz, want.zl, got.dx, got.dy, got.dz, got.zl);
            fail_count <= fail_count + 1;
          end
        end
      end
      // Items still in flight
      pending <= ray_queue.size();
    end
  end
endmodule

// File: tb/tb_camera_ray_direction.sv
module tb_camera_ray_direction;
  import crd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [2:0]       cfg_index = '0;
  logic [VEC_W-1:0] cfg_data = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [55:0]      s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [55:0]      m_axis_tdata;
  logic             m_axis_tuser;
  int               fail_count, pending, rays_seen, zero_seen;
  bit               steady = 1'b0;
  bit               hold_off = 1'b0;
  int               items_sent = 0;

  camera_ray_direction dut (.*);

  camera_ray_direction_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_valid(s_axis_tvalid), .s_ready(s_axis_tready), .s_data(s_axis_tdata),
    .m_valid(m_axis_tvalid), .m_ready(m_axis_tready), .m_data(m_axis_tdata),
    .m_user(m_axis_tuser), .fail_count(fail_count), .pending(pending),
    .rays_seen(rays_seen), .zero_seen(zero_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Randomly stall the receiver, or hold it off entirely
  always @(negedge clk) begin
    if (rst || hold_off) m_axis_tready <= 1'b0;
    else m_axis_tready <= steady || ($urandom_range(99) >= 35);
  end

  // Long receiver hold-off, counted in cycles
  initial begin
    wait (items_sent > 600);
    @(negedge clk);
    hold_off = 1'b1;
    repeat (300) @(negedge clk);
    hold_off = 1'b0;
  end

  function automatic logic [VEC_W-1:0] rand_vec();
    logic [VEC_W-1:0] v;
    v = VEC_W'({$urandom, $urandom});
    // Mostly small components so the sums stay meaningful
    for (int i = 0; i < 3; i++)
      if ($urandom_range(3) != 0)
        v[i*COMP_W +: COMP_W] = COMP_W'($urandom_range(32768) - 16384);
    return v;
  endfunction

  task automatic write_reg(input reg_index_t idx, input logic [VEC_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Offer one pixel item and hold it until accepted
  task automatic send_pixel(input logic [11:0] col, input logic [11:0] row,
                            input logic [15:0] jx, input logic [15:0] jy);
    while (!steady && $urandom_range(99) < 35) @(negedge clk);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {jy, jx, row, col};
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    @(negedge clk);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (70) @(negedge clk);
  endtask

  task automatic random_pixels(input int n);
    for (int i = 0; i < n; i++)
      send_pixel(12'($urandom), 12'($urandom), 16'($urandom), 16'($urandom));
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // Directed: default camera, field extremes
    send_pixel(12'd0, 12'd0, 16'd0, 16'd0);
    send_pixel(12'hFFF, 12'hFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(12'd320, 12'd240, 16'd0, 16'd0);
    send_pixel(12'd319, 12'd240, 16'hFFFF, 16'd0);
    send_pixel(12'd0, 12'hFFF, 16'hFFFF, 16'd0);
    send_pixel(12'hFFF, 12'd0, 16'd0, 16'hFFFF);
    drain();

    // Zero width, height and pitch, coincident look-at and eye: zero vectors; then maximum pitch, width and height
    write_reg(REG_IMAGE_WIDTH, 63'd0);
    write_reg(REG_IMAGE_HEIGHT, 63'd0);
    write_reg(REG_PIXEL_PITCH, 63'd0);
    send_pixel(12'd5, 12'd7, 16'd100, 16'd200);
    send_pixel(12'hFFF, 12'hFFF, 16'hFFFF, 16'hFFFF);
    drain();
    write_reg(REG_PIXEL_PITCH, 63'hFFFFFF);
    write_reg(REG_IMAGE_WIDTH, 63'h1FFF);
    write_reg(REG_IMAGE_HEIGHT, 63'h1FFF);
    send_pixel(12'd0, 12'd0, 16'd0, 16'd0);
    send_pixel(12'hFFF, 12'hFFF, 16'hFFFF, 16'hFFFF);
    drain();

    // Extreme axes and points
    write_reg(REG_IMAGE_WIDTH, 63'd4096);
    write_reg(REG_IMAGE_HEIGHT, 63'd1);
    write_reg(REG_RIGHT_AXIS, {3{21'h100000}});
    write_reg(REG_UP_AXIS, {3{21'h0FFFFF}});
    write_reg(REG_LOOK_AT, {3{21'h0FFFFF}});
    write_reg(REG_EYE, {3{21'h100000}});
    send_pixel(12'd0, 12'd0, 16'd0, 16'd0);
    send_pixel(12'hFFF, 12'hFFF, 16'hFFFF, 16'hFFFF);
    drain();
    write_reg(REG_RIGHT_AXIS, 63'h7FFF_FFFF_FFFF_FFFF);
    write_reg(REG_UP_AXIS, 63'd0);
    write_reg(REG_LOOK_AT, 63'd0);
    write_reg(REG_EYE, 63'd0);
    send_pixel(12'd2048, 12'd0, 16'd0, 16'd0);
    send_pixel(12'd2047, 12'd9, 16'd1, 16'hFFFF);
    drain();

    // Random camera settings, mostly a modest pitch
    for (int ph = 0; ph < 16; ph++) begin
      write_reg(REG_IMAGE_WIDTH, 63'($urandom_range(4096, 1)));
      write_reg(REG_IMAGE_HEIGHT, 63'($urandom_range(4096, 1)));
      write_reg(REG_PIXEL_PITCH, ($urandom_range(3) == 0) ? 63'($urandom) :
                                 63'($urandom_range(65536 * 4, 1)));
      write_reg(REG_RIGHT_AXIS, rand_vec());
      write_reg(REG_UP_AXIS, rand_vec());
      write_reg(REG_LOOK_AT, rand_vec());
      write_reg(REG_EYE, ($urandom_range(4) == 0) ? 63'd0 : rand_vec());
      steady = (ph == 3);
      random_pixels(100);
      steady = 1'b0;
      drain();
    end

    $display("Sent %0d pixel items over 21 camera settings; %0d rays checked, %0d zero length.",
             items_sent, rays_seen, zero_seen);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Run time limit
  initial begin
    #2ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
